// ===== rtl/core/rrsg_pkg.sv =====
// rrsg_pkg: shared types, constants and the generator step for the run/sleep task gate
// no dependencies
package rrsg_pkg;

    localparam int SLOT_W  = 6;
    localparam int GROUP_W = 23;
    localparam int EPOCH_W = 32;
    localparam int TIME_W  = 64;
    localparam int QCNT_W  = 16;
    localparam int SLICE_W = 32;
    localparam int WIN_W   = 32;
    localparam int PRNG_W  = 64;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 64;
    localparam int PHASE_W = 2;

    localparam logic [CIDX_W-1:0] CFG_RUN_MIN      = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_RUN_MAX      = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_SLEEP_MIN    = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_SLEEP_MAX    = 8'd3;
    localparam logic [CIDX_W-1:0] CFG_TARGET_SLICE = 8'd4;
    localparam logic [CIDX_W-1:0] CFG_OTHER_SLICE  = 8'd5;
    localparam logic [CIDX_W-1:0] CFG_SHRINK       = 8'd6;
    localparam logic [CIDX_W-1:0] CFG_SEED         = 8'd7;

    localparam logic [PHASE_W-1:0] PH_START = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RUN   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SLEEP = 2'd2;

    typedef struct packed {
        logic [SLOT_W-1:0]  task_slot;
        logic [GROUP_W-1:0] task_group;
        logic [GROUP_W-1:0] parent_group;
        logic [GROUP_W-1:0] target_group;
        logic [EPOCH_W-1:0] epoch;
        logic [TIME_W-1:0]  now_time;
        logic [QCNT_W-1:0]  queued_count;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  eligible_time;
        logic [SLICE_W-1:0] slice_length;
        logic               is_target;
    } out_item_t;

    typedef struct packed {
        logic [WIN_W-1:0]   run_min;
        logic [WIN_W-1:0]   run_max;
        logic [WIN_W-1:0]   sleep_min;
        logic [WIN_W-1:0]   sleep_max;
        logic [SLICE_W-1:0] target_slice;
        logic [SLICE_W-1:0] other_slice;
        logic               shrink;
    } cfg_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               related;
        logic               has_entry;
        logic [EPOCH_W-1:0] epoch;
        logic [TIME_W-1:0]  now_time;
        logic [SLICE_W-1:0] slice;
    } work_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [TIME_W-1:0]  deadline;
        logic [EPOCH_W-1:0] epoch;
    } entry_t;

    function automatic logic [PRNG_W-1:0] xorshift(input logic [PRNG_W-1:0] w);
        logic [PRNG_W-1:0] x;
        x = w;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

endpackage

// ===== rtl/core/rrsg_front.sv =====
// rrsg_front: accepts items, classifies them and works out the slice
// depends on rrsg_pkg
module rrsg_front #(
    parameter int TASK_SLOTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rrsg_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  rrsg_pkg::in_item_t s_data,
    output logic              push_valid,
    input  logic              push_ready,
    output rrsg_pkg::work_t   push_data
);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

    fstate_t state_reg, state_next;
    rrsg_pkg::work_t work_reg, work_next;
    logic [16:0] dvsr_reg, dvsr_next;
    logic [16:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic        related;
    logic [17:0] shifted;
    logic        q_bit;

    assign related = (s_data.target_group != '0) &&
                     ((s_data.task_group == s_data.target_group) ||
                      (s_data.parent_group == s_data.target_group));
    assign shifted = {rem_reg, work_reg.slice[rrsg_pkg::SLICE_W-1]};
    assign q_bit   = shifted >= {1'b0, dvsr_reg};

    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);

    always_comb begin
        push_data = work_reg;
        if (cfg.shrink && work_reg.slice == '0) begin
            push_data.slice = rrsg_pkg::SLICE_W'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        work_next  = work_reg;
        dvsr_next  = dvsr_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    work_next.slot      = s_data.task_slot;
                    work_next.related   = related;
                    work_next.has_entry = {26'd0, s_data.task_slot} < 32'(TASK_SLOTS);
                    work_next.epoch     = s_data.epoch;
                    work_next.now_time  = s_data.now_time;
                    work_next.slice     = related ? cfg.target_slice : cfg.other_slice;
                    dvsr_next = {1'b0, s_data.queued_count} + 17'd1;
                    rem_next  = '0;
                    cnt_next  = '0;
                    if (cfg.shrink && s_data.queued_count != '0) begin
                        state_next = F_DIV;
                    end else begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV: begin
                rem_next = q_bit ? 17'(shifted - {1'b0, dvsr_reg}) : shifted[16:0];
                work_next.slice = {work_reg.slice[rrsg_pkg::SLICE_W-2:0], q_bit};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        work_reg <= work_next;
        dvsr_reg <= dvsr_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

endmodule

// ===== rtl/core/rrsg_queue.sv =====
// rrsg_queue: two-entry queue of classified items between front and back
// depends on rrsg_pkg
module rrsg_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rrsg_pkg::work_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rrsg_pkg::work_t rd_data
);

    rrsg_pkg::work_t slots_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slots_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wp_next  = do_wr ? ~wp_reg : wp_reg;
        rp_next  = do_rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (do_wr) begin
            slots_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/rrsg_back.sv =====
// rrsg_back: task table, generator, window draw and result register
// depends on rrsg_pkg
module rrsg_back #(
    parameter int TASK_SLOTS = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rrsg_pkg::cfg_t         cfg,
    input  logic                   seed_wr,
    input  logic [rrsg_pkg::PRNG_W-1:0] seed_value,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  rrsg_pkg::work_t        pop_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rrsg_pkg::out_item_t    m_data
);

    localparam int IDXW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    typedef enum logic [2:0] {B_CLR, B_IDLE, B_RD, B_OPEN, B_MOD, B_WR, B_FIN} bstate_t;

    rrsg_pkg::entry_t mem [TASK_SLOTS];
    rrsg_pkg::entry_t rd_reg;

    bstate_t state_reg, state_next;
    rrsg_pkg::work_t work_reg, work_next;
    logic [IDXW-1:0] clr_reg, clr_next;
    logic [rrsg_pkg::PRNG_W-1:0] prng_reg, prng_next;
    logic [rrsg_pkg::PHASE_W-1:0] ph_reg, ph_next;
    logic [rrsg_pkg::WIN_W-1:0] min_reg, min_next;
    logic [63:0] dvsr_reg, dvsr_next;
    logic [36:0] dvd_reg, dvd_next;
    logic [36:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [rrsg_pkg::TIME_W-1:0] elig_reg, elig_next;
    logic m_valid_reg, m_valid_next;
    rrsg_pkg::out_item_t m_data_reg, m_data_next;

    logic [IDXW-1:0] addr;
    logic [12:0]     slot_ext;
    logic [12:0]     pop_ext;
    logic [IDXW-1:0] rd_addr;
    logic            mem_we;
    logic [IDXW-1:0] mem_wa;
    rrsg_pkg::entry_t mem_wd;
    logic [rrsg_pkg::PRNG_W-1:0] drawn;
    logic [rrsg_pkg::WIN_W-1:0] sel_min, sel_max;
    logic [32:0] span;
    logic [36:0] r31;
    logic [37:0] shifted;
    logic        sub_ok;
    logic [rrsg_pkg::TIME_W-1:0] deadline;
    logic        expired;

    assign slot_ext = {7'd0, work_reg.slot};
    assign addr     = slot_ext[IDXW-1:0];
    // table read is issued while the item is popped so it is ready in B_RD
    assign pop_ext  = {7'd0, pop_data.slot};
    assign rd_addr  = (state_reg == B_IDLE) ? pop_ext[IDXW-1:0] : addr;
    assign drawn    = rrsg_pkg::xorshift(prng_reg);
    assign sel_min  = (ph_reg == rrsg_pkg::PH_RUN) ? cfg.run_min : cfg.sleep_min;
    assign sel_max  = (ph_reg == rrsg_pkg::PH_RUN) ? cfg.run_max : cfg.sleep_max;
    assign span     = {1'b0, sel_max} - {1'b0, sel_min};
    assign r31      = {drawn[31:0], 5'd0} - {5'd0, drawn[31:0]};
    assign shifted  = {rem_reg, dvd_reg[36]};
    assign sub_ok   = {26'd0, shifted} >= dvsr_reg;
    assign deadline = work_reg.now_time + {32'd0, min_reg} + {27'd0, rem_reg};
    assign expired  = work_reg.now_time >= rd_reg.deadline;

    assign pop_ready = (state_reg == B_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        work_next    = work_reg;
        clr_next     = clr_reg;
        prng_next    = prng_reg;
        ph_next      = ph_reg;
        min_next     = min_reg;
        dvsr_next    = dvsr_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        elig_next    = elig_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_wa       = addr;
        mem_wd       = '0;
        case (state_reg)
            B_CLR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + IDXW'(1);
                if (clr_reg == IDXW'(TASK_SLOTS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (pop_valid) begin
                    work_next = pop_data;
                    elig_next = pop_data.now_time;
                    if (pop_data.related && pop_data.has_entry) begin
                        state_next = B_RD;
                    end else begin
                        state_next = B_FIN;
                    end
                end
            end
            B_RD: begin
                if (rd_reg.epoch != work_reg.epoch || rd_reg.phase == rrsg_pkg::PH_START) begin
                    prng_next  = drawn;
                    ph_next    = drawn[0] ? rrsg_pkg::PH_RUN : rrsg_pkg::PH_SLEEP;
                    state_next = B_OPEN;
                end else if (rd_reg.phase == rrsg_pkg::PH_RUN) begin
                    if (expired) begin
                        ph_next    = rrsg_pkg::PH_SLEEP;
                        state_next = B_OPEN;
                    end else begin
                        state_next = B_FIN;
                    end
                end else begin
                    if (expired) begin
                        ph_next    = rrsg_pkg::PH_RUN;
                        state_next = B_OPEN;
                    end else begin
                        elig_next  = rd_reg.deadline;
                        state_next = B_FIN;
                    end
                end
            end
            B_OPEN: begin
                min_next = sel_min;
                rem_next = '0;
                cnt_next = '0;
                if (sel_min == sel_max) begin
                    state_next = B_WR;
                end else begin
                    prng_next  = drawn;
                    dvd_next   = r31;
                    dvsr_next  = {{31{span[32]}}, span};
                    state_next = B_MOD;
                end
            end
            B_MOD: begin
                rem_next = sub_ok ? 37'(shifted - dvsr_reg[37:0]) : shifted[36:0];
                dvd_next = {dvd_reg[35:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd36) begin
                    state_next = B_WR;
                end
            end
            B_WR: begin
                mem_we         = 1'b1;
                mem_wd.phase   = ph_reg;
                mem_wd.deadline = deadline;
                mem_wd.epoch   = work_reg.epoch;
                elig_next  = (ph_reg == rrsg_pkg::PH_RUN) ? work_reg.now_time : deadline;
                state_next = B_FIN;
            end
            B_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.eligible_time  = elig_reg;
                    m_data_next.slice_length   = work_reg.slice;
                    m_data_next.is_target      = work_reg.related;
                    state_next                 = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
        if (seed_wr) begin
            prng_next = seed_value | rrsg_pkg::PRNG_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLR;
            clr_reg     <= '0;
            prng_reg    <= rrsg_pkg::PRNG_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            prng_reg    <= prng_next;
            m_valid_reg <= m_valid_next;
        end
        work_reg   <= work_next;
        ph_reg     <= ph_next;
        min_reg    <= min_next;
        dvsr_reg   <= dvsr_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        elig_reg   <= elig_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/random_run_sleep_task_gate.sv =====
// random_run_sleep_task_gate: top level, configuration registers and channel wiring
// depends on rrsg_pkg, rrsg_front, rrsg_queue, rrsg_back
//
//  channel   ports                          payload
//  input     s_valid s_ready s_data         rrsg_pkg::in_item_t
//  result    m_valid m_ready m_data         rrsg_pkg::out_item_t
//  config    cfg_wr_en cfg_index cfg_wdata  64-bit write, no read-back
//
// front: one item at a time; with shrink set and a nonzero queued count,
// the slice is divided bit-serially by the queued count plus one
// back: one item at a time; window lengths are drawn by a bit-serial modulo
// after reset the task table is cleared entry by entry before items flow
// front and back stall on their own across a two-item queue
module random_run_sleep_task_gate #(
    parameter int TASK_SLOTS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rrsg_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [rrsg_pkg::CDATA_W-1:0]      cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rrsg_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rrsg_pkg::out_item_t               m_data
);

    rrsg_pkg::cfg_t cfg_reg, cfg_next;
    logic seed_wr;

    logic            q_in_valid, q_in_ready;
    rrsg_pkg::work_t q_in_data;
    logic            q_out_valid, q_out_ready;
    rrsg_pkg::work_t q_out_data;

    assign seed_wr = cfg_wr_en && (cfg_index == rrsg_pkg::CFG_SEED);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rrsg_pkg::CFG_RUN_MIN:      cfg_next.run_min      = cfg_wdata[31:0];
                rrsg_pkg::CFG_RUN_MAX:      cfg_next.run_max      = cfg_wdata[31:0];
                rrsg_pkg::CFG_SLEEP_MIN:    cfg_next.sleep_min    = cfg_wdata[31:0];
                rrsg_pkg::CFG_SLEEP_MAX:    cfg_next.sleep_max    = cfg_wdata[31:0];
                rrsg_pkg::CFG_TARGET_SLICE: cfg_next.target_slice = cfg_wdata[31:0];
                rrsg_pkg::CFG_OTHER_SLICE:  cfg_next.other_slice  = cfg_wdata[31:0];
                rrsg_pkg::CFG_SHRINK:       cfg_next.shrink       = cfg_wdata[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rrsg_front #(.TASK_SLOTS(TASK_SLOTS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data)
    );

    rrsg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_in_data),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_out_data)
    );

    rrsg_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .seed_wr    (seed_wr),
        .seed_value (cfg_wdata),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_data   (q_out_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
